/* sv/greedy_box_nms_unit_defines.svh */
// ----------------------------------------------------------------------------
// greedy_box_nms_unit_defines.svh
// Assertion macros shared by the box suppression unit.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_UNIT_DEFINES_SVH
`define GREEDY_BOX_NMS_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define GBN_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define GBN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Widths, storage layout and overlap helper for the box suppression unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);

	localparam int COORD_W = 16;
	localparam int SCORE_W = 16;
	localparam int CLASS_W = 4;
	localparam int TAG_W   = 16;
	localparam int THR_W   = 9;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

	// overlap extent in doubled units, intersection and union times four
	localparam int EXT_W  = COORD_W + 1;
	localparam int AREA_W = 2 * COORD_W;
	localparam int I4_W   = 2 * EXT_W;
	localparam int U4_W   = AREA_W + 3;
	localparam int CMP_W  = U4_W + THR_W;
	localparam int EDGE_W = COORD_W + 4;

	typedef struct packed {
		logic [COORD_W-1:0] h;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cx;
	} geom_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [CLASS_W-1:0] class_id;
		logic [SCORE_W-1:0] score;
	} meta_t;

	localparam int GEOM_W = $bits(geom_t);
	localparam int META_W = $bits(meta_t);

	// Overlap along one axis: edges at 2c-s and 2c+s, clamped at zero
	function automatic logic [EXT_W-1:0] overlap2(
		input logic [COORD_W-1:0] c1,
		input logic [COORD_W-1:0] s1,
		input logic [COORD_W-1:0] c2,
		input logic [COORD_W-1:0] s2
	);
		logic signed [EDGE_W-1:0] lo1, lo2, hi1, hi2, lo, hi, d;
		lo1 = $signed({3'b000, c1, 1'b0}) - $signed({4'b0000, s1});
		lo2 = $signed({3'b000, c2, 1'b0}) - $signed({4'b0000, s2});
		hi1 = $signed({3'b000, c1, 1'b0}) + $signed({4'b0000, s1});
		hi2 = $signed({3'b000, c2, 1'b0}) + $signed({4'b0000, s2});
		lo  = (lo1 > lo2) ? lo1 : lo2;
		hi  = (hi1 < hi2) ? hi1 : hi2;
		d   = hi - lo;
		return (d > 0) ? d[EXT_W-1:0] : '0;
	endfunction

endpackage

/* sv/greedy_box_nms_unit.sv */
// Loading: one box per cycle; the set's last box starts the suppression run.
// Run: each pass streams the stored boxes, one per cycle, from the box memories
//   through one five-stage overlap pipeline; the first pass finds the first pick, and
//   each later pass drops the boxes that overlap the kept box and finds the next pick.
// Input is not ready during the run; a kept box may wait in the output register.
// Reset clears the live marks, box count and overflow flag and sets the threshold to 128.
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Greedy non-maximum suppression by intersection-over-union. Boxes of a set
// are stored in two RAMs; a sequencer repeatedly picks the best live box,
// drops every overlapping live box of the same class and emits the pick.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_unit_defines.svh"

module greedy_box_nms_unit
	import gbn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [THR_W-1:0]   cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] center_x,
	input  logic [COORD_W-1:0] center_y,
	input  logic [COORD_W-1:0] box_width,
	input  logic [COORD_W-1:0] box_height,
	input  logic [SCORE_W-1:0] score,
	input  logic [CLASS_W-1:0] class_id,
	input  logic [TAG_W-1:0]   tag,
	input  logic               last_box,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] kept_center_x,
	output logic [COORD_W-1:0] kept_center_y,
	output logic [COORD_W-1:0] kept_width,
	output logic [COORD_W-1:0] kept_height,
	output logic [SCORE_W-1:0] kept_score,
	output logic [CLASS_W-1:0] kept_class,
	output logic [TAG_W-1:0]   kept_tag,
	output logic               overflow,
	output logic               last_result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_LOAD,
		ST_CAPT
	} state_t;

	state_t             state_q;
	logic [THR_W-1:0]   thr_q;
	logic [CNT_W-1:0]   box_count_q;
	logic               overflow_q;
	logic [MAX_BOXES-1:0] live_q;
	logic [CNT_W-1:0]   issue_cnt_q;
	logic               have_kept_q;
	logic               best_found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic               out_valid_q;
	logic               last_q;

	// kept box
	geom_t              k_geom_q;
	meta_t              k_meta_q;
	logic [AREA_W-1:0]  area_k_q;

	// scan pipeline
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]   idx_s1, idx_s2, idx_s3, idx_s4;
	geom_t              geom_rd;
	meta_t              meta_rd;
	logic [EXT_W-1:0]   iw_s2, ih_s2;
	logic [AREA_W-1:0]  area_s2;
	logic               same_s2, same_s3, same_s4;
	logic [SCORE_W-1:0] score_s2, score_s3, score_s4;
	logic [I4_W-1:0]    i4_s3, i4_s4;
	logic [U4_W-1:0]    asum_s3, u4_s4;

	logic               in_fire;
	logic               store_box;
	logic               issue;
	logic               scan_done;
	logic               emit_fire;
	logic [IDX_W-1:0]   raddr;
	logic [CMP_W-1:0]   lhs, rhs;
	logic               suppress;
	logic               live_j;
	logic               take_best;

	// ------------------------------------------------------------------
	// Handshakes and sequencer controls
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign store_box = in_fire && (box_count_q < CNT_W'(MAX_BOXES));
	assign issue     = (state_q == ST_SCAN) && (issue_cnt_q < box_count_q);
	assign scan_done = (state_q == ST_SCAN) && (issue_cnt_q == box_count_q)
		&& !(v_s1 || v_s2 || v_s3 || v_s4);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign raddr     = (state_q == ST_LOAD) ? best_idx_q : issue_cnt_q[IDX_W-1:0];

	// ------------------------------------------------------------------
	// Box storage
	// ------------------------------------------------------------------
	gbn_ram #(
		.WIDTH (GEOM_W),
		.DEPTH (MAX_BOXES)
	) u_geom_ram (
		.clk   (clk),
		.we    (store_box),
		.waddr (box_count_q[IDX_W-1:0]),
		.wdata ({box_height, box_width, center_y, center_x}),
		.raddr (raddr),
		.rdata (geom_rd)
	);

	gbn_ram #(
		.WIDTH (META_W),
		.DEPTH (MAX_BOXES)
	) u_meta_ram (
		.clk   (clk),
		.we    (store_box),
		.waddr (box_count_q[IDX_W-1:0]),
		.wdata ({tag, class_id, score}),
		.raddr (raddr),
		.rdata (meta_rd)
	);

	// ------------------------------------------------------------------
	// Final stage: overlap test, suppression and best-candidate tracking
	// ------------------------------------------------------------------
	assign lhs       = CMP_W'({i4_s4, 8'h00});
	assign rhs       = {{U4_W{1'b0}}, thr_q} * {{THR_W{1'b0}}, u4_s4};
	assign suppress  = have_kept_q && same_s4 && (lhs > rhs);
	assign live_j    = live_q[idx_s4];
	assign take_best = v_s4 && live_j && !suppress
		&& (!best_found_q || (score_s4 > best_score_q));

	// ------------------------------------------------------------------
	// Pipeline valid bits
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline datapath and kept box
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// stage 1 index follows the RAM read
		idx_s1   <= issue_cnt_q[IDX_W-1:0];

		// stage 2: overlap extents and area of the scanned box
		idx_s2   <= idx_s1;
		iw_s2    <= overlap2(k_geom_q.cx, k_geom_q.w, geom_rd.cx, geom_rd.w);
		ih_s2    <= overlap2(k_geom_q.cy, k_geom_q.h, geom_rd.cy, geom_rd.h);
		area_s2  <= {{COORD_W{1'b0}}, geom_rd.w} * {{COORD_W{1'b0}}, geom_rd.h};
		same_s2  <= (meta_rd.class_id == k_meta_q.class_id);
		score_s2 <= meta_rd.score;

		// stage 3: intersection and area sum
		idx_s3   <= idx_s2;
		i4_s3    <= {{(I4_W-EXT_W){1'b0}}, iw_s2} * {{(I4_W-EXT_W){1'b0}}, ih_s2};
		asum_s3  <= U4_W'({area_k_q, 2'b00}) + U4_W'({area_s2, 2'b00});
		same_s3  <= same_s2;
		score_s3 <= score_s2;

		// stage 4: union
		idx_s4   <= idx_s3;
		i4_s4    <= i4_s3;
		u4_s4    <= asum_s3 - U4_W'(i4_s3);
		same_s4  <= same_s3;
		score_s4 <= score_s3;

		// capture the picked box
		if (state_q == ST_CAPT) begin
			k_geom_q <= geom_rd;
			k_meta_q <= meta_rd;
			area_k_q <= {{COORD_W{1'b0}}, geom_rd.w} * {{COORD_W{1'b0}}, geom_rd.h};
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: state, set bookkeeping and registered outputs
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			thr_q         <= THR_RESET;
			box_count_q   <= '0;
			overflow_q    <= 1'b0;
			live_q        <= '0;
			issue_cnt_q   <= '0;
			have_kept_q   <= 1'b0;
			best_found_q  <= 1'b0;
			best_idx_q    <= '0;
			best_score_q  <= '0;
			out_valid_q   <= 1'b0;
			last_q        <= 1'b0;
			overflow      <= 1'b0;
			kept_center_x <= '0;
			kept_center_y <= '0;
			kept_width    <= '0;
			kept_height   <= '0;
			kept_score    <= '0;
			kept_class    <= '0;
			kept_tag      <= '0;
		end else begin
			// take a threshold write
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end

			// drop the output once it is taken and nothing replaces it
			if (out_valid_q && out_ready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end

			// advance the scan counter
			if (issue) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end

			// kill suppressed boxes, track the best survivor
			if (v_s4 && suppress) begin
				live_q[idx_s4] <= 1'b0;
			end
			if (take_best) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s4;
				best_score_q <= score_s4;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (store_box) begin
							live_q[box_count_q[IDX_W-1:0]] <= 1'b1;
							box_count_q <= box_count_q + 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
						if (last_box) begin
							issue_cnt_q  <= '0;
							have_kept_q  <= 1'b0;
							best_found_q <= 1'b0;
							state_q      <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (have_kept_q) begin
							state_q <= ST_EMIT;
						end else if (best_found_q) begin
							state_q <= ST_LOAD;
						end else begin
							box_count_q <= '0;
							overflow_q  <= 1'b0;
							live_q      <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						out_valid_q   <= 1'b1;
						last_q        <= !best_found_q;
						overflow      <= overflow_q;
						kept_center_x <= k_geom_q.cx;
						kept_center_y <= k_geom_q.cy;
						kept_width    <= k_geom_q.w;
						kept_height   <= k_geom_q.h;
						kept_score    <= k_meta_q.score;
						kept_class    <= k_meta_q.class_id;
						kept_tag      <= k_meta_q.tag;
						if (best_found_q) begin
							state_q <= ST_LOAD;
						end else begin
							box_count_q <= '0;
							overflow_q  <= 1'b0;
							live_q      <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_LOAD: begin
					// read the pick and retire it
					live_q[best_idx_q] <= 1'b0;
					state_q            <= ST_CAPT;
				end
				ST_CAPT: begin
					issue_cnt_q  <= '0;
					have_kept_q  <= 1'b1;
					best_found_q <= 1'b0;
					state_q      <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign last_result = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`GBN_ASSERT_ALWAYS(a_count_range, box_count_q <= CNT_W'(MAX_BOXES), "box count beyond capacity")
	`GBN_ASSERT_IMPL(a_first_pick, scan_done && !have_kept_q, best_found_q, "set ended with no live box")
	`GBN_ASSERT_IMPL(a_final_clear, emit_fire && !best_found_q, live_q == '0, "live box left at set end")
	`GBN_ASSERT_IMPL(a_best_stored, best_found_q, CNT_W'(best_idx_q) < box_count_q, "pick outside stored boxes")

endmodule

/* sv/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sim/tb_greedy_box_nms_unit.sv */
// ----------------------------------------------------------------------------
// tb_greedy_box_nms_unit
// Self-checking bench for the greedy box suppression unit. Box sets go in over
// a valid/ready channel and kept boxes come back over another. A behavioral
// model of the unit predicts each set's kept boxes in order. Directed sets
// probe field extremes, overlap rules and threshold edges, and random
// clustered sets run under several thresholds with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_greedy_box_nms_unit
	import gbn_pkg::*;
();

	localparam int RUN_SETTLE  = 160;   // settling margin after the last kept box, above one full pass
	localparam int STALL_LIMIT = 5000;  // cycles without any request moving

	typedef struct {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [SCORE_W-1:0] score;
		logic [CLASS_W-1:0] cls;
		logic [TAG_W-1:0]   tag;
		logic               last;
	} box_t;

	typedef struct {
		box_t box;
		logic dropped_any;
		logic set_end;
	} kept_box_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [THR_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [COORD_W-1:0] center_x = '0;
	logic [COORD_W-1:0] center_y = '0;
	logic [COORD_W-1:0] box_width = '0;
	logic [COORD_W-1:0] box_height = '0;
	logic [SCORE_W-1:0] score = '0;
	logic [CLASS_W-1:0] class_id = '0;
	logic [TAG_W-1:0]   tag = '0;
	logic               last_box = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COORD_W-1:0] kept_center_x;
	logic [COORD_W-1:0] kept_center_y;
	logic [COORD_W-1:0] kept_width;
	logic [COORD_W-1:0] kept_height;
	logic [SCORE_W-1:0] kept_score;
	logic [CLASS_W-1:0] kept_class;
	logic [TAG_W-1:0]   kept_tag;
	logic               overflow;
	logic               last_result;

	// model state of the unit
	box_t             set_boxes [MAX_BOXES];
	logic             set_live [MAX_BOXES];
	int               set_count = 0;
	logic             set_dropped = 1'b0;
	logic [THR_W-1:0] thr_model = THR_RESET;

	kept_box_t kept_boxes_due [$];
	int        mismatches = 0;
	int        boxes_sent = 0;
	int        stall_cycles = 0;
	logic      no_idle = 1'b0;

	greedy_box_nms_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.center_x(center_x), .center_y(center_y),
		.box_width(box_width), .box_height(box_height),
		.score(score), .class_id(class_id), .tag(tag), .last_box(last_box),
		.out_valid(out_valid), .out_ready(out_ready),
		.kept_center_x(kept_center_x), .kept_center_y(kept_center_y),
		.kept_width(kept_width), .kept_height(kept_height),
		.kept_score(kept_score), .kept_class(kept_class), .kept_tag(kept_tag),
		.overflow(overflow), .last_result(last_result)
	);

	always #5 clk = ~clk;

	// Stall the result side with a chance of 31 in 100, unless no_idle is set
	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
	end

	// ------------------------------------------------------------------
	// Box model
	// ------------------------------------------------------------------

	// Overlap along one axis in doubled units, clamped at zero
	function automatic longint axis_overlap(input logic [COORD_W-1:0] c1, s1, c2, s2);
		longint lo1, lo2, hi1, hi2, lo, hi;
		lo1 = 2 * longint'(c1) - longint'(s1);
		lo2 = 2 * longint'(c2) - longint'(s2);
		hi1 = 2 * longint'(c1) + longint'(s1);
		hi2 = 2 * longint'(c2) + longint'(s2);
		lo  = (lo1 > lo2) ? lo1 : lo2;
		hi  = (hi1 < hi2) ? hi1 : hi2;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	// Kept box knocks out another when same class and IoU above the threshold
	function automatic logic overlap_kills(input box_t keep, input box_t other);
		longint i4, u4;
		if (keep.cls != other.cls)
			return 1'b0;
		i4 = axis_overlap(keep.cx, keep.w, other.cx, other.w) *
			axis_overlap(keep.cy, keep.h, other.cy, other.h);
		u4 = 4 * longint'(keep.w) * longint'(keep.h) +
			4 * longint'(other.w) * longint'(other.h) - i4;
		return 256 * i4 > longint'(thr_model) * u4;
	endfunction

	// Store one box; on the set's last box run the greedy pass and queue the picks
	function automatic void store_and_suppress(input box_t b);
		int        best;
		box_t      picks [$];
		kept_box_t pick;
		if (set_count < MAX_BOXES) begin
			set_boxes[set_count] = b;
			set_live[set_count] = 1'b1;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!b.last)
			return;
		forever begin
			best = -1;
			for (int i = 0; i < set_count; i++)
				if (set_live[i] && (best < 0 || set_boxes[i].score > set_boxes[best].score))
					best = i;
			if (best < 0)
				break;
			set_live[best] = 1'b0;
			for (int j = 0; j < set_count; j++)
				if (set_live[j] && overlap_kills(set_boxes[best], set_boxes[j]))
					set_live[j] = 1'b0;
			picks.insert(picks.size(), set_boxes[best]);
		end
		foreach (picks[k]) begin
			pick.box = picks[k];
			pick.dropped_any = set_dropped;
			pick.set_end = (k == picks.size() - 1);
			kept_boxes_due.insert(kept_boxes_due.size(), pick);
		end
		set_count = 0;
		set_dropped = 1'b0;
	endfunction

	function automatic void check_field(input string name, input longint want, got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: check results, feed the model, watch for a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		kept_box_t want;
		box_t      arrived;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			// compare each accepted kept box with the oldest prediction
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (kept_boxes_due.size() == 0) begin
					$error("unexpected kept box, tag %0d", kept_tag);
					mismatches++;
				end else begin
					want = kept_boxes_due.pop_front();
					check_field("kept_center_x", longint'(want.box.cx),
						longint'(kept_center_x));
					check_field("kept_center_y", longint'(want.box.cy),
						longint'(kept_center_y));
					check_field("kept_width", longint'(want.box.w), longint'(kept_width));
					check_field("kept_height", longint'(want.box.h), longint'(kept_height));
					check_field("kept_score", longint'(want.box.score), longint'(kept_score));
					check_field("kept_class", longint'(want.box.cls), longint'(kept_class));
					check_field("kept_tag", longint'(want.box.tag), longint'(kept_tag));
					check_field("overflow", longint'(want.dropped_any), longint'(overflow));
					check_field("last_result", longint'(want.set_end), longint'(last_result));
				end
			end
			// advance the model on each accepted box request
			if (in_valid && in_ready) begin
				moved = 1'b1;
				arrived.cx = center_x;
				arrived.cy = center_y;
				arrived.w = box_width;
				arrived.h = box_height;
				arrived.score = score;
				arrived.cls = class_id;
				arrived.tag = tag;
				arrived.last = last_box;
				store_and_suppress(arrived);
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				thr_model = cfg_data;
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Send one box request, idling at random first; hold until accepted
	task automatic send_box(input box_t b);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		center_x <= b.cx;
		center_y <= b.cy;
		box_width <= b.w;
		box_height <= b.h;
		score <= b.score;
		class_id <= b.cls;
		tag <= b.tag;
		last_box <= b.last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		boxes_sent++;
	endtask

	// Drop valid and wait until every predicted kept box has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (kept_boxes_due.size() != 0)
			@(negedge clk);
	endtask

	// Write the threshold once the unit has gone idle
	task automatic set_threshold(input logic [THR_W-1:0] value);
		drain_results();
		repeat (RUN_SETTLE) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic box_t mk_box(input int cx, cy, w, h, sc, cls, id, input logic last);
		box_t b;
		b.cx = COORD_W'(cx);
		b.cy = COORD_W'(cy);
		b.w = COORD_W'(w);
		b.h = COORD_W'(h);
		b.score = SCORE_W'(sc);
		b.cls = CLASS_W'(cls);
		b.tag = TAG_W'(id);
		b.last = last;
		return b;
	endfunction

	// Random set: mostly one cluster over two classes, some boxes pure noise
	task automatic send_random_set(input int n_boxes);
		int               base_x, base_y, spread, score_base;
		logic [CLASS_W-1:0] cls_a, cls_b;
		box_t             b;
		base_x = $urandom_range(4000, 61000);
		base_y = $urandom_range(4000, 61000);
		spread = $urandom_range(0, 1500);
		score_base = $urandom_range(0, 65532);
		cls_a = CLASS_W'($urandom);
		cls_b = CLASS_W'($urandom);
		for (int i = 0; i < n_boxes; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				b.cx = COORD_W'($urandom);
				b.cy = COORD_W'($urandom);
				b.w = COORD_W'($urandom);
				b.h = COORD_W'($urandom);
				b.score = SCORE_W'($urandom);
				b.cls = CLASS_W'($urandom);
			end else begin
				b.cx = COORD_W'(base_x + $urandom_range(0, 2 * spread) - spread);
				b.cy = COORD_W'(base_y + $urandom_range(0, 2 * spread) - spread);
				b.w = COORD_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(200, 3000));
				b.h = COORD_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(200, 3000));
				b.score = $urandom_range(0, 1) ? SCORE_W'($urandom) :
					SCORE_W'(score_base + $urandom_range(0, 3));
				b.cls = $urandom_range(0, 1) ? cls_a : cls_b;
			end
			b.tag = TAG_W'($urandom);
			b.last = (i == n_boxes - 1);
			send_box(b);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extremes of every field, at the reset threshold
	task automatic test_field_extremes();
		send_box(mk_box(0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_box(mk_box(65535, 65535, 65535, 65535, 65535, 15, 65535, 1'b0));
		send_box(mk_box(0, 65535, 65535, 65535, 1, 15, 'h5a5a, 1'b0));
		send_box(mk_box('h8000, 'h8000, 'h10, 'h10, 'h8000, 7, 'ha5a5, 1'b1));
	endtask

	// Equal scores, other class, zero union and a weak overlap
	task automatic test_overlap_rules();
		send_box(mk_box(1000, 1000, 200, 200, 900, 3, 1, 1'b0));
		send_box(mk_box(1000, 1000, 200, 200, 900, 3, 2, 1'b0));
		send_box(mk_box(1000, 1000, 200, 200, 900, 4, 3, 1'b0));
		send_box(mk_box(1000, 1000, 0, 0, 950, 3, 4, 1'b0));
		send_box(mk_box(1100, 1000, 200, 200, 800, 3, 5, 1'b0));
		send_box(mk_box(1000, 1000, 0, 0, 100, 3, 6, 1'b1));
	endtask

	// Threshold at zero, just below one, at one and at the register's top
	task automatic test_threshold_edges();
		set_threshold(0);
		send_box(mk_box(500, 500, 100, 100, 10, 2, 10, 1'b0));
		send_box(mk_box(599, 500, 100, 100, 9, 2, 11, 1'b0));
		send_box(mk_box(700, 700, 0, 0, 8, 2, 12, 1'b0));
		send_box(mk_box(700, 700, 0, 0, 8, 2, 13, 1'b1));
		set_threshold(255);
		send_box(mk_box(3000, 2000, 400, 300, 70, 9, 20, 1'b0));
		send_box(mk_box(3000, 2000, 400, 300, 60, 9, 21, 1'b1));
		set_threshold(256);
		send_box(mk_box(3000, 2000, 400, 300, 70, 9, 22, 1'b0));
		send_box(mk_box(3000, 2000, 400, 300, 60, 9, 23, 1'b1));
		set_threshold(511);
		send_box(mk_box(3000, 2000, 400, 300, 70, 9, 24, 1'b0));
		send_box(mk_box(3000, 2000, 400, 300, 60, 9, 25, 1'b1));
	endtask

	// Random sets in phases of different thresholds, with a full and an overfull set
	task automatic test_random_sets();
		logic [THR_W-1:0] phase_thr [7] = '{128, 0, 256, 511, 200, 96, 0};
		int               target, roll, n_boxes;
		for (int p = 0; p < 7; p++) begin
			set_threshold((p == 6) ? THR_W'($urandom_range(0, 256)) : phase_thr[p]);
			no_idle = (p == 4);
			target = boxes_sent + 58;
			if (p == 3)
				send_random_set(MAX_BOXES);
			if (p == 5)
				send_random_set(MAX_BOXES + 6);
			while (boxes_sent < target) begin
				// now and then hold off until the previous set is fully out
				if ($urandom_range(0, 3) == 0)
					drain_results();
				roll = $urandom_range(0, 99);
				n_boxes = (roll < 70) ? $urandom_range(1, 6) :
					(roll < 95) ? $urandom_range(7, 16) : $urandom_range(17, 40);
				send_random_set(n_boxes);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_overlap_rules();
		test_threshold_edges();
		test_random_sets();
		drain_results();
		repeat (RUN_SETTLE) @(negedge clk);
		if (kept_boxes_due.size() != 0) begin
			$error("%0d kept boxes never arrived", kept_boxes_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
